// ===== src/tlvrl_pkg.sv =====
// Shared types and constants for the TLV record locator.
`timescale 1ns / 1ps

package tlvrl_pkg;

  localparam int IMAGE_BYTES = 4096;
  localparam int POS_W       = $clog2(IMAGE_BYTES) + 1;
  localparam logic [POS_W-1:0] LAST_POS = POS_W'(IMAGE_BYTES - 1);

  localparam logic [7:0] MAGIC_BYTE = 8'h41;

  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;

  typedef enum logic [0:0] {
    REG_SEARCH_ID      = 1'b0,
    REG_FORMAT_VERSION = 1'b1
  } reg_idx_t;

  typedef enum logic [1:0] {
    ST_FOUND      = 2'd0,
    ST_BAD_HEADER = 2'd1,
    ST_TERMINATOR = 2'd2,
    ST_IMAGE_END  = 2'd3
  } status_t;

  typedef enum logic [5:0] {
    PH_MAGIC   = 6'b000001,
    PH_VERSION = 6'b000010,
    PH_ID      = 6'b000100,
    PH_SIZE_LO = 6'b001000,
    PH_SIZE_HI = 6'b010000,
    PH_SKIP    = 6'b100000
  } phase_t;

  typedef struct packed {
    logic [7:0] search_id;
    logic [7:0] format_version;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [12:0] payload_offset;
    logic [15:0] payload_size;
  } res_t;

endpackage

// ===== src/tlvrl_record_locator_top.sv =====
// Top level of the TLV record locator.
`timescale 1ns / 1ps

// Streams a settings image one byte per beat and hunts for one record id.
// The image is a magic byte (0x41), a version byte, then records of
// id / 16-bit little-endian size / payload; payloads of other ids are
// skipped. Exactly one result beat comes out per image: found (with the
// offset of the first payload byte and the size), bad magic or version,
// id-0 terminator, or image ended (also when a header is cut off or the
// image reaches 4096 bytes). After a result, bytes up to the one flagged
// last_byte are swallowed without output; last_byte rearms the parser.
// Throughput is one byte per clock while in_stall is low: each byte is a
// phase update, a counter step and a few compares in the parser, and its
// result, if any, is registered in the output stage in the next cycle.
// A two-entry output stage (result register plus skid) keeps input
// flowing while the sink stalls; in_stall rises only once both entries
// hold undelivered results. search_id and format_version sit at APB byte
// addresses 0 and 4; write them only while no image is in flight.
module tlv_record_locator_top
  import tlvrl_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  // image byte channel
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [7:0]        data_byte,
  input  logic              last_byte,
  // result channel
  output logic              out_valid,
  input  logic              out_stall,
  output logic [1:0]        status,
  output logic [12:0]       payload_offset,
  output logic [15:0]       payload_size,
  // configuration
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  cfg_t cfg;
  logic accept;
  logic res_valid;
  res_t res;
  res_t out_data;
  logic buf_full;

  assign in_stall = buf_full;
  assign accept   = in_valid & ~buf_full;

  tlvrl_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  tlvrl_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .data_byte (data_byte),
    .last_byte (last_byte),
    .cfg       (cfg),
    .res_valid (res_valid),
    .res       (res)
  );

  tlvrl_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (res_valid),
    .push_data (res),
    .full      (buf_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  assign status         = out_data.status;
  assign payload_offset = out_data.payload_offset;
  assign payload_size   = out_data.payload_size;

endmodule

// ===== src/tlvrl_cfg.sv =====
// APB register file: search id and expected format version.
`timescale 1ns / 1ps

module tlvrl_cfg
  import tlvrl_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg
);

  cfg_t     regs;
  reg_idx_t idx;
  logic     wr_en;

  // word aligned: low address bits are ignored
  assign idx    = reg_idx_t'(paddr[2]);
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;
  assign cfg    = regs;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.search_id      <= 8'd1;
      regs.format_version <= 8'd1;
    end else if (wr_en) begin
      unique case (idx)
        REG_SEARCH_ID:      regs.search_id      <= pwdata[7:0];
        REG_FORMAT_VERSION: regs.format_version <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_SEARCH_ID:      prdata = {{(DATA_W-8){1'b0}}, regs.search_id};
      REG_FORMAT_VERSION: prdata = {{(DATA_W-8){1'b0}}, regs.format_version};
      default:            prdata = '0;
    endcase
  end

endmodule

// ===== src/tlvrl_parser.sv =====
// Per-byte image parser: phase tracking, payload skipping, result decision.
`timescale 1ns / 1ps

module tlvrl_parser
  import tlvrl_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  logic [7:0] data_byte,
  input  logic       last_byte,
  input  cfg_t       cfg,
  output logic       res_valid,
  output res_t       res
);

  phase_t           phase, phase_next;
  logic [POS_W-1:0] pos;
  logic             id_matched, id_matched_next;
  logic [7:0]       size_lo, size_lo_next;
  logic [15:0]      skip, skip_next;
  logic             decided;

  logic             at_end;
  logic             emit;
  logic [15:0]      size_word;
  logic [15:0]      skip_dec;

  assign at_end    = last_byte | (pos >= LAST_POS);
  assign size_word = {data_byte, size_lo};
  assign skip_dec  = (skip != 16'd0) ? skip - 16'd1 : 16'd0;

  always_comb begin
    phase_next      = phase;
    id_matched_next = id_matched;
    size_lo_next    = size_lo;
    skip_next       = skip;
    emit            = 1'b0;
    res.status         = ST_FOUND;
    res.payload_offset = '0;
    res.payload_size   = '0;

    unique case (phase)
      PH_MAGIC: begin
        if (data_byte != MAGIC_BYTE) begin
          res.status = ST_BAD_HEADER;
          emit       = 1'b1;
        end else begin
          phase_next = PH_VERSION;
        end
      end
      PH_VERSION: begin
        if (data_byte != cfg.format_version) begin
          res.status = ST_BAD_HEADER;
          emit       = 1'b1;
        end else begin
          phase_next = PH_ID;
        end
      end
      PH_ID: begin
        if (data_byte == 8'd0) begin
          res.status = ST_TERMINATOR;
          emit       = 1'b1;
        end else begin
          id_matched_next = (data_byte == cfg.search_id);
          phase_next      = PH_SIZE_LO;
        end
      end
      PH_SIZE_LO: begin
        size_lo_next = data_byte;
        phase_next   = PH_SIZE_HI;
      end
      PH_SIZE_HI: begin
        if (id_matched) begin
          res.status         = ST_FOUND;
          res.payload_offset = 13'(pos + POS_W'(1));
          res.payload_size   = size_word;
          emit               = 1'b1;
        end else if (size_word == 16'd0) begin
          phase_next = PH_ID;
        end else begin
          skip_next  = size_word;
          phase_next = PH_SKIP;
        end
      end
      PH_SKIP: begin
        skip_next = skip_dec;
        if (skip_dec == 16'd0) phase_next = PH_ID;
      end
      default: phase_next = PH_MAGIC;
    endcase

    // image end with nothing decided yet
    if (!emit && at_end) begin
      res.status         = ST_IMAGE_END;
      res.payload_offset = '0;
      res.payload_size   = '0;
      emit               = 1'b1;
    end
  end

  assign res_valid = accept & ~decided & emit;

  always_ff @(posedge clk) begin
    if (rst || (accept && last_byte)) begin
      phase      <= PH_MAGIC;
      pos        <= '0;
      id_matched <= 1'b0;
      size_lo    <= '0;
      skip       <= '0;
      decided    <= 1'b0;
    end else if (accept && !decided) begin
      phase      <= phase_next;
      id_matched <= id_matched_next;
      size_lo    <= size_lo_next;
      skip       <= skip_next;
      if (emit) decided <= 1'b1;
      else      pos     <= pos + POS_W'(1);
    end
  end

endmodule

// ===== src/tlvrl_out_buf.sv =====
// Result register with a skid stage so input keeps flowing under output stall.
`timescale 1ns / 1ps

module tlvrl_out_buf
  import tlvrl_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  res_t push_data,
  output logic full,
  output logic out_valid,
  input  logic out_stall,
  output res_t out_data
);

  logic skid_valid;
  res_t skid_data;
  logic pop;

  assign pop  = out_valid & ~out_stall;
  assign full = skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (pop) begin
        out_data   <= skid_data;
        skid_valid <= 1'b0;
      end
    end else if (push) begin
      if (out_valid && !pop) begin
        skid_data  <= push_data;
        skid_valid <= 1'b1;
      end else begin
        out_data  <= push_data;
        out_valid <= 1'b1;
      end
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

endmodule
